// ===== hw/rtl/dstu_pkg.sv =====
// shared types, codes and width tables for the decimal string parser
package dstu_pkg;

  localparam int ValueWidth = 64;
  localparam int CountWidth = 5;
  // exact leading-digit term: at most 9 * 10^19, below 2^67
  localparam int TopWidth   = 68;
  localparam int SumWidth   = TopWidth + 1;

  localparam logic [CountWidth-1:0] MaxCount = 5'd20;
  localparam logic [7:0]            CharZero = 8'h30;
  localparam logic [7:0]            CharNine = 8'h39;

  typedef enum logic [1:0] {
    MODE_8  = 2'd0,
    MODE_16 = 2'd1,
    MODE_32 = 2'd2,
    MODE_64 = 2'd3
  } width_mode_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NOT_FOUND    = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  // what the parser asks the result stage to report
  typedef enum logic [1:0] {
    REQ_NOT_FOUND    = 2'd0,
    REQ_OUT_OF_RANGE = 2'd1,
    REQ_END          = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    status_t               status;
    logic [CountWidth-1:0] consumed;
  } out_beat_t;

  typedef struct packed {
    req_kind_t             kind;
    width_mode_t           mode;
    logic [TopWidth-1:0]   top;
    logic [ValueWidth-1:0] rest;
    logic [CountWidth-1:0] count;
  } req_t;

  // digit limit of each target width
  function automatic logic [CountWidth-1:0] digit_limit(width_mode_t m);
    logic [CountWidth-1:0] r;
    unique case (m)
      MODE_8:  r = 5'd3;
      MODE_16: r = 5'd5;
      MODE_32: r = 5'd10;
      MODE_64: r = 5'd20;
      default: r = 5'd20;
    endcase
    return r;
  endfunction

  // bits that may be set in a value that fits the target width
  function automatic logic [SumWidth-1:0] limit_mask(width_mode_t m);
    logic [SumWidth-1:0] r;
    unique case (m)
      MODE_8:  r = SumWidth'(8'hFF);
      MODE_16: r = SumWidth'(16'hFFFF);
      MODE_32: r = SumWidth'(32'hFFFF_FFFF);
      MODE_64: r = SumWidth'(64'hFFFF_FFFF_FFFF_FFFF);
      default: r = SumWidth'(64'hFFFF_FFFF_FFFF_FFFF);
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/dstu_parser.sv =====
// per-character parse state machine and digit accumulation
module dstu_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat_valid,
  input  dstu_pkg::in_beat_t   beat,
  input  dstu_pkg::width_mode_t mode,
  input  logic                 res_free,
  output logic                 beat_take,
  output logic                 req_valid,
  output dstu_pkg::req_t       req
);
  import dstu_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_PEEK   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  phase_t                phase, phase_next;
  logic [TopWidth-1:0]   top, top_next;
  logic [ValueWidth-1:0] rest, rest_next;
  logic [CountWidth-1:0] count, count_next;
  logic                  emit;
  req_kind_t             kind;
  logic                  is_digit;
  logic [7:0]            ch_off;
  logic [3:0]            digit;
  logic [CountWidth-1:0] maxd;
  phase_t                after;
  logic [TopWidth-1:0]   top_x10;
  logic [ValueWidth-1:0] rest_x10;

  // the beat moves on when the request register is free or draining
  assign beat_take = beat_valid && (!req_valid || res_free);

  // character decode
  assign ch_off   = beat.ch - CharZero;
  assign is_digit = beat.has_char && (beat.ch >= CharZero) && (beat.ch <= CharNine);
  assign digit    = is_digit ? ch_off[3:0] : 4'd0;
  assign maxd     = digit_limit(mode);
  assign after    = beat.is_last ? PH_START : PH_SKIP;

  // times ten as two shifts and an add
  assign top_x10  = (top << 3) + (top << 1);
  assign rest_x10 = (rest << 3) + (rest << 1) + ValueWidth'(digit);

  // next state and result request
  always_comb begin
    phase_next = phase;
    top_next   = top;
    rest_next  = rest;
    count_next = count;
    emit       = 1'b0;
    kind       = REQ_END;
    unique case (phase)
      PH_START: begin
        if (!beat.has_char) begin
          if (beat.is_last) begin
            emit = 1'b1;
            kind = REQ_NOT_FOUND;
          end
        end else if (!is_digit) begin
          emit       = 1'b1;
          kind       = REQ_NOT_FOUND;
          phase_next = after;
        end else begin
          top_next   = TopWidth'(digit);
          rest_next  = '0;
          count_next = CountWidth'(1);
          if (beat.is_last) begin
            emit       = 1'b1;
            phase_next = PH_START;
          end else if (CountWidth'(1) >= maxd) begin
            phase_next = PH_PEEK;
          end else begin
            phase_next = PH_DIGITS;
          end
        end
      end
      PH_DIGITS: begin
        if (!beat.has_char) begin
          if (beat.is_last) begin
            emit       = 1'b1;
            phase_next = PH_START;
          end
        end else if (!is_digit) begin
          emit       = 1'b1;
          phase_next = after;
        end else begin
          top_next   = top_x10;
          rest_next  = rest_x10;
          count_next = count + CountWidth'(1);
          if (beat.is_last) begin
            emit       = 1'b1;
            phase_next = PH_START;
          end else if (count_next >= maxd) begin
            phase_next = PH_PEEK;
          end
        end
      end
      PH_PEEK: begin
        if (!beat.has_char) begin
          if (beat.is_last) begin
            emit       = 1'b1;
            phase_next = PH_START;
          end
        end else if (is_digit) begin
          emit       = 1'b1;
          kind       = REQ_OUT_OF_RANGE;
          phase_next = after;
        end else begin
          emit       = 1'b1;
          phase_next = after;
        end
      end
      PH_SKIP: begin
        if (beat.is_last) begin
          phase_next = PH_START;
        end
      end
      default: phase_next = PH_START;
    endcase
  end

  // state and request register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      count     <= '0;
      req_valid <= 1'b0;
    end else begin
      if (beat_take) begin
        phase     <= phase_next;
        top       <= top_next;
        rest      <= rest_next;
        count     <= count_next;
        req_valid <= emit;
        if (emit) begin
          req.kind  <= kind;
          req.mode  <= mode;
          req.top   <= top_next;
          req.rest  <= rest_next;
          req.count <= count_next;
        end
      end else if (res_free) begin
        req_valid <= 1'b0;
      end
    end
  end

  // a string end always returns to the start phase
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    beat_take && beat.is_last |=> phase == PH_START)
    else $error("parser did not return to start after last beat");

  // the digit run never passes the widest limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCount)
    else $error("digit count above limit");

  // an idle beat leaves the parse untouched
  a_idle_beat: assert property (@(posedge clk) disable iff (rst)
    beat_take && !beat.has_char && !beat.is_last |=> $stable(phase) && $stable(count))
    else $error("idle beat changed parse state");

endmodule

// ===== hw/rtl/dstu_result.sv =====
// range check and result register with output handshake
module dstu_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  dstu_pkg::req_t      req,
  input  logic                out_stall,
  output logic                res_free,
  output logic                out_valid,
  output dstu_pkg::out_beat_t out_data
);
  import dstu_pkg::*;

  logic [SumWidth-1:0] sum;
  logic                over;
  out_beat_t           beat_next;

  // exact value and width check
  assign sum  = SumWidth'(req.top) + SumWidth'(req.rest);
  assign over = |(sum & ~limit_mask(req.mode));

  // result formatting
  always_comb begin
    beat_next.value    = '0;
    beat_next.status   = STATUS_OUT_OF_RANGE;
    beat_next.consumed = '0;
    unique case (req.kind)
      REQ_NOT_FOUND:    beat_next.status = STATUS_NOT_FOUND;
      REQ_OUT_OF_RANGE: beat_next.status = STATUS_OUT_OF_RANGE;
      REQ_END: begin
        if (!over) begin
          beat_next.value    = sum[ValueWidth-1:0];
          beat_next.status   = STATUS_OK;
          beat_next.consumed = req.count;
        end
      end
      default: beat_next.status = STATUS_OUT_OF_RANGE;
    endcase
  end

  assign res_free = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= req_valid;
      if (req_valid) begin
        out_data <= beat_next;
      end
    end
  end

  // an ok result always counts at least one digit
  a_ok_has_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_OK |-> out_data.consumed != '0)
    else $error("ok result with no digits");

  // error results carry zero value and count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |->
      out_data.value == '0 && out_data.consumed == '0)
    else $error("error result with nonzero payload");

endmodule

// ===== hw/rtl/decimal_string_to_unsigned.sv =====
// Decimal string parser: takes one character per beat and reports the leading ASCII digit
// run as an unsigned value of 8, 16, 32 or 64 bits (width_mode), with ok, not_found or
// out_of_range; one result at most per string, the rest skipped up to is_last. A new
// character beat is taken every cycle unless a stalled result holds the request register;
// the parser stage folds one digit per cycle into the running value with a times-ten shift
// and add. A result is valid on out_* after its deciding beat passes the parser request
// register, then the output register, and is taken at the first later edge with out_stall
// low; a stalled result holds back the beats behind it. width_mode must be written through
// cfg_* only while the block is idle; the block itself does not enforce it.
module decimal_string_to_unsigned (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dstu_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dstu_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);
  import dstu_pkg::*;

  logic        in_q_valid;
  in_beat_t    in_q;
  logic        in_accept;
  logic        beat_take;
  logic        req_valid;
  req_t        req;
  logic        res_free;
  width_mode_t width_mode;

  // input register
  assign in_stall  = in_q_valid && !beat_take;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
      in_q       <= in_data;
    end else if (beat_take) begin
      in_q_valid <= 1'b0;
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= MODE_8;
    end else if (cfg_valid) begin
      width_mode <= width_mode_t'(cfg_data);
    end
  end

  dstu_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (in_q_valid),
    .beat       (in_q),
    .mode       (width_mode),
    .res_free   (res_free),
    .beat_take  (beat_take),
    .req_valid  (req_valid),
    .req        (req)
  );

  dstu_result u_result (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .out_stall (out_stall),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== verif/decimal_string_to_unsigned_test.sv =====
// self-checking testbench for the decimal string to unsigned parser
`timescale 1ns / 1ps

module decimal_string_to_unsigned_test;
  import dstu_pkg::*;

  localparam int DrainCycles = 6;
  localparam int RandomBeats = 1400;

  typedef enum logic [1:0] {
    SCAN_START  = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_PEEK   = 2'd2,
    SCAN_SKIP   = 2'd3
  } scan_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  // parser state as the block should hold it
  width_mode_t cur_width = MODE_8;
  logic [3:0]  lead_digit = '0;
  logic [63:0] rest_val = '0;
  logic [63:0] place_val = 64'd1;
  logic [4:0]  n_digits = '0;
  scan_state_t scan = SCAN_START;

  out_beat_t   pending_results[$];
  int          fail_count = 0;
  int          counted_beats = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_pct = 0;

  decimal_string_to_unsigned u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("decimal_string_to_unsigned_test: FAIL");
    $finish;
  end

  // digit limit, leading digit limit and value cap per width
  function automatic void width_limits(input width_mode_t m, output logic [4:0] maxd,
                                       output logic [3:0] msd, output logic [63:0] cap);
    case (m)
      MODE_8: begin
        maxd = 5'd3;  msd = 4'd2; cap = 64'hFF;
      end
      MODE_16: begin
        maxd = 5'd5;  msd = 4'd6; cap = 64'hFFFF;
      end
      MODE_32: begin
        maxd = 5'd10; msd = 4'd4; cap = 64'hFFFF_FFFF;
      end
      default: begin
        maxd = 5'd20; msd = 4'd1; cap = 64'hFFFF_FFFF_FFFF_FFFF;
      end
    endcase
  endfunction

  function automatic out_beat_t make_result(input logic [63:0] v, input status_t st,
                                            input logic [4:0] cnt);
    out_beat_t r;
    r.value = v;
    r.status = st;
    r.consumed = cnt;
    return r;
  endfunction

  // result for the digits taken so far, range checked at the full digit count
  function automatic out_beat_t end_result();
    logic [4:0]  maxd;
    logic [3:0]  msd;
    logic [63:0] cap;
    logic [67:0] top;
    logic [68:0] sum;
    width_limits(cur_width, maxd, msd, cap);
    if (n_digits < maxd)
      return make_result(place_val * 64'(lead_digit) + rest_val, STATUS_OK, n_digits);
    top = 68'(place_val) * 68'(lead_digit);
    sum = 69'(top) + 69'(rest_val);
    if (lead_digit > msd || top[67:64] != 4'd0 || sum > 69'(cap))
      return make_result('0, STATUS_OUT_OF_RANGE, '0);
    return make_result(sum[63:0], STATUS_OK, n_digits);
  endfunction

  // advance the expected parser by one accepted beat
  task automatic parse_char(input in_beat_t b);
    logic        dig;
    logic [3:0]  d;
    logic [4:0]  maxd;
    logic [3:0]  msd;
    logic [63:0] cap;
    scan_state_t after;
    dig = b.has_char && b.ch >= CharZero && b.ch <= CharNine;
    d = dig ? 4'(b.ch - CharZero) : 4'd0;
    width_limits(cur_width, maxd, msd, cap);
    after = b.is_last ? SCAN_START : SCAN_SKIP;
    counted_beats++;
    case (scan)
      SCAN_START: begin
        if (!b.has_char) begin
          if (b.is_last)
            pending_results.push_back(make_result('0, STATUS_NOT_FOUND, '0));
        end else if (!dig) begin
          pending_results.push_back(make_result('0, STATUS_NOT_FOUND, '0));
          scan = after;
        end else begin
          lead_digit = d;
          rest_val = '0;
          place_val = 64'd1;
          n_digits = 5'd1;
          if (b.is_last) begin
            pending_results.push_back(end_result());
            scan = SCAN_START;
          end else begin
            scan = (n_digits >= maxd) ? SCAN_PEEK : SCAN_DIGITS;
          end
        end
      end
      SCAN_DIGITS: begin
        if (!b.has_char) begin
          if (b.is_last) begin
            pending_results.push_back(end_result());
            scan = SCAN_START;
          end
        end else if (!dig) begin
          pending_results.push_back(end_result());
          scan = after;
        end else begin
          place_val = place_val * 64'd10;
          rest_val = rest_val * 64'd10 + 64'(d);
          n_digits = n_digits + 5'd1;
          if (b.is_last) begin
            pending_results.push_back(end_result());
            scan = SCAN_START;
          end else if (n_digits >= maxd) begin
            scan = SCAN_PEEK;
          end
        end
      end
      SCAN_PEEK: begin
        if (!b.has_char) begin
          if (b.is_last) begin
            pending_results.push_back(end_result());
            scan = SCAN_START;
          end
        end else if (dig) begin
          pending_results.push_back(make_result('0, STATUS_OUT_OF_RANGE, '0));
          scan = after;
        end else begin
          pending_results.push_back(end_result());
          scan = after;
        end
      end
      default: begin
        if (b.is_last)
          scan = SCAN_START;
      end
    endcase
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_result
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d consumed %0d",
               out_data.value, out_data.status, out_data.consumed);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, out_data.consumed);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern: stretches of a random stall rate, some with none
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(10, 80);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 25;
        3:       stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic in_beat_t make_beat(input logic [7:0] c, input logic has,
                                         input logic last);
    in_beat_t b;
    b.ch = c;
    b.has_char = has;
    b.is_last = last;
    return b;
  endfunction

  function automatic logic [7:0] other_char();
    logic [7:0] c;
    // the neighbors of the digit range come up often
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) != 0) ? CharZero - 8'd1 : CharNine + 8'd1;
    do c = 8'($urandom_range(0, 255)); while (c >= CharZero && c <= CharNine);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  // send one beat, then maybe end the burst with a gap
  task automatic send_beat(input in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++)
      send_beat(make_beat(s[i], 1'b1, 1'(ends && i == s.len() - 1)));
  endtask

  task automatic send_end_beat();
    send_beat(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // hold off until all results are out and the pipeline has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_width(input width_mode_t m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_width = m;
    cfg_valid <= 1'b0;
  endtask

  // one random string: mostly digit runs, some boundary values and noise
  task automatic send_random_string();
    logic [7:0]  txt[$];
    logic [4:0]  maxd;
    logic [3:0]  msd;
    logic [63:0] cap;
    logic [63:0] v;
    int          kind;
    int          zeros;
    int          term;
    width_limits(cur_width, maxd, msd, cap);
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 8))
        send_beat(make_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) != 0),
                            1'($urandom_range(0, 3) == 0)));
      return;
    end
    case (kind)
      4: begin
        // leading zeros count as digits
        zeros = $urandom_range(1, maxd);
        repeat (zeros) txt.push_back(CharZero);
        repeat ($urandom_range(0, maxd + 1 - zeros)) txt.push_back(digit_char());
      end
      5: txt.push_back(other_char());
      6, 7: begin
        // just at, below or above the value cap of the width
        v = cap;
        do begin
          txt.push_front(CharZero + 8'(v % 64'd10));
          v = v / 64'd10;
        end while (v != 0);
        if (kind == 6)
          txt[txt.size() - 1] -= 8'($urandom_range(0, 5));
        else
          txt[txt.size() - 1] += 8'($urandom_range(1, 4));
      end
      default: begin
        repeat ($urandom_range(1, maxd + 1)) txt.push_back(digit_char());
      end
    endcase
    // end on the last char, after a terminator and junk, or with an end-only beat
    term = $urandom_range(0, 2);
    if (term == 1) begin
      txt.push_back(other_char());
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
    end
    foreach (txt[i]) begin
      if ($urandom_range(0, 11) == 0)
        send_beat(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      send_beat(make_beat(txt[i], 1'b1, 1'(term != 2 && i == txt.size() - 1)));
    end
    if (term == 2)
      send_end_beat();
  endtask

  // 8 bit width as left by reset
  task automatic test_default_width();
    send_text("255", 1'b1);
    send_text("256", 1'b1);
    send_text("0000", 1'b1);
    wait_idle();
  endtask

  // empty string, non-digit starts and an idle beat inside a string
  task automatic test_no_digits();
    send_end_beat();
    send_text("x9", 1'b1);
    send_text("/", 1'b1);
    send_text(":5", 1'b1);
    send_text("4", 1'b0);
    send_beat(make_beat(8'h35, 1'b0, 1'b0));
    send_text(";", 1'b1);
    wait_idle();
  endtask

  // width narrowed while a digit run is open
  task automatic test_width_change_mid_string();
    set_width(MODE_32);
    send_text("1234", 1'b0);
    wait_idle();
    set_width(MODE_8);
    send_text("5", 1'b0);
    send_end_beat();
    wait_idle();
  endtask

  // full digit count one above the 16 bit cap, then a terminator
  task automatic test_width_16_edge();
    set_width(MODE_16);
    send_text("65536;", 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    set_width(MODE_64);
    counted_beats = 0;
    while (counted_beats < RandomBeats) begin
      if ($urandom_range(0, 39) == 0) begin
        wait_idle();
        set_width(width_mode_t'($urandom_range(0, 3)));
      end
      send_random_string();
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_width();
    test_no_digits();
    test_width_change_mid_string();
    test_width_16_edge();
    test_random();
    if (fail_count == 0)
      $display("decimal_string_to_unsigned_test: PASS");
    else
      $display("decimal_string_to_unsigned_test: FAIL");
    $finish;
  end

endmodule
